// ===== hw/rtl/mf_pkg.sv =====
// Shared types and constants for the 3x3 median filter.
package mf_pkg;

    // Configuration register map.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int ROWS_CFG_W = 13;
    localparam int COLS_CFG_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = CFG_IDX_W'(1);

    // Grid size after reset, before clamping to the build limits.
    localparam int ROWS_RESET = 4096;
    localparam int COLS_RESET = 1024;

    // Smallest grid side that gets filtered; smaller grids pass through.
    localparam int MIN_DIM = 3;

    // Cells in the 3x3 window.
    localparam int WIN_CELLS = 9;

    // Result slots of one item, in emission order.
    localparam int SLOT_A = 0;
    localparam int SLOT_B = 1;
    localparam int SLOT_C = 2;
    localparam int SLOTS  = 3;

    // Per-item control that travels down the pipeline.
    // slot A: raw pixel, raw left border of the previous row, or a median.
    // slot B: raw right border of the previous row.
    // slot C: raw pixel of the last row.
    typedef struct packed {
        logic [SLOTS-1:0] slot;
        logic             a_prev;
        logic             a_med;
        logic             eof_a;
        logic             eof_c;
        logic             pass_all;
    } mf_flags_t;

endpackage

// ===== hw/rtl/mf_if.sv =====
// Valid/ready stream interfaces for pixels in and filtered cells out.
interface mf_pix_if #(
    parameter int SW = 16
);
    logic          valid;
    logic          ready;
    logic [SW-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface mf_res_if #(
    parameter int ROW_W = 12,
    parameter int COL_W = 10,
    parameter int SW    = 16
);
    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic [SW-1:0]    out_value;
    logic             last_of_step;
    logic             end_of_frame;

    modport source (
        output valid, output out_row, output out_col, output out_value,
        output last_of_step, output end_of_frame, input ready
    );
    modport sink (
        input valid, input out_row, input out_col, input out_value,
        input last_of_step, input end_of_frame, output ready
    );
endinterface

// ===== hw/rtl/mf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module mf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/mf_median.sv =====
// Three-stage pipelined median of nine values with a sideband that travels alongside.
module mf_median import mf_pkg::*; #(
    parameter int SW     = 16,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [SW-1:0]     win [WIN_CELLS],
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SW-1:0]     med,
    output logic [SIDE_W-1:0] side_out
);

    // Sorts three values; result is {high, middle, low}.
    function automatic logic [3*SW-1:0] sort3(input logic [SW-1:0] a,
                                               input logic [SW-1:0] b,
                                               input logic [SW-1:0] c);
        logic [SW-1:0] l1, h1, l2, h2, lo, mi;
        l1 = (a < b) ? a : b;
        h1 = (a < b) ? b : a;
        l2 = (h1 < c) ? h1 : c;
        h2 = (h1 < c) ? c : h1;
        lo = (l1 < l2) ? l1 : l2;
        mi = (l1 < l2) ? l2 : l1;
        return {h2, mi, lo};
    endfunction

    logic              v1_reg, v2_reg, v3_reg;
    logic              rdy1, rdy2, rdy3;
    logic [SW-1:0]     lo_reg [3];
    logic [SW-1:0]     mi_reg [3];
    logic [SW-1:0]     hi_reg [3];
    logic [SW-1:0]     mx_reg, md_reg, mn_reg, med_reg;
    logic [SIDE_W-1:0] side1_reg, side2_reg, side3_reg;
    logic [3*SW-1:0]   row_sort [3];
    logic [3*SW-1:0]   lo_sort, mi_sort, hi_sort, fin_sort;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            row_sort[k] = sort3(win[3*k], win[3*k+1], win[3*k+2]);
        end
    end

    // The median of nine is the middle of the largest row minimum, the middle
    // row median and the smallest row maximum.
    assign lo_sort  = sort3(lo_reg[0], lo_reg[1], lo_reg[2]);
    assign mi_sort  = sort3(mi_reg[0], mi_reg[1], mi_reg[2]);
    assign hi_sort  = sort3(hi_reg[0], hi_reg[1], hi_reg[2]);
    assign fin_sort = sort3(mx_reg, md_reg, mn_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            for (int k = 0; k < 3; k++)
            begin
                lo_reg[k] <= row_sort[k][SW-1:0];
                mi_reg[k] <= row_sort[k][2*SW-1:SW];
                hi_reg[k] <= row_sort[k][3*SW-1:2*SW];
            end
            side1_reg <= side_in;
        end
        if (rdy2)
        begin
            mx_reg    <= lo_sort[3*SW-1:2*SW];
            md_reg    <= mi_sort[2*SW-1:SW];
            mn_reg    <= hi_sort[SW-1:0];
            side2_reg <= side1_reg;
        end
        if (rdy3)
        begin
            med_reg   <= fin_sort[2*SW-1:SW];
            side3_reg <= side2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign med       = med_reg;
    assign side_out  = side3_reg;

endmodule

// ===== hw/rtl/mf_emit.sv =====
// Output stage that hands out the up to three results of one item, one per cycle while the results side is ready.
module mf_emit import mf_pkg::*; #(
    parameter int ROW_W = 12,
    parameter int COL_W = 10,
    parameter int SW    = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  mf_flags_t        flags,
    input  logic [ROW_W-1:0] row,
    input  logic [COL_W-1:0] col,
    input  logic [SW-1:0]    pix,
    input  logic [SW-1:0]    mid,
    input  logic [SW-1:0]    med,
    mf_res_if.source         res
);

    logic [SLOTS-1:0] pend_reg, pend_next;
    mf_flags_t        fl_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic [SW-1:0]    pix_reg, mid_reg, med_reg;
    logic             one_left;
    logic             load;

    // Exactly one result left means the one on show is the last of its item.
    assign one_left = (pend_reg != '0)
                   && ((pend_reg & (pend_reg - SLOTS'(1))) == '0);
    assign in_ready = (pend_reg == '0) || (one_left && res.ready);
    assign load     = in_valid && in_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (load)
        begin
            pend_next = flags.slot;
        end
        else if (res.valid && res.ready)
        begin
            pend_next = pend_reg & (pend_reg - SLOTS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fl_reg  <= flags;
            row_reg <= row;
            col_reg <= col;
            pix_reg <= pix;
            mid_reg <= mid;
            med_reg <= med;
        end
    end

    always_comb
    begin
        res.valid        = pend_reg != '0;
        res.last_of_step = one_left;
        if (pend_reg[SLOT_A])
        begin
            res.out_row      = fl_reg.a_prev ? row_reg - ROW_W'(1) : row_reg;
            res.out_col      = fl_reg.a_med ? col_reg - COL_W'(1) : col_reg;
            res.out_value    = fl_reg.a_med ? med_reg : (fl_reg.a_prev ? mid_reg : pix_reg);
            res.end_of_frame = fl_reg.eof_a;
        end
        else if (pend_reg[SLOT_B])
        begin
            res.out_row      = row_reg - ROW_W'(1);
            res.out_col      = col_reg;
            res.out_value    = mid_reg;
            res.end_of_frame = 1'b0;
        end
        else
        begin
            res.out_row      = row_reg;
            res.out_col      = col_reg;
            res.out_value    = pix_reg;
            res.end_of_frame = fl_reg.eof_c;
        end
    end

endmodule

// ===== hw/rtl/median_filter_3x3.sv =====
// Top level of the streaming 3x3 median filter over a raster-order grid.
//
//  Channel   Dir  Handshake         Payload
//  pixels    in   valid / ready     pixel_value
//  results   out  valid / ready     out_row, out_col, out_value, last_of_step, end_of_frame
//  cfg       in   cfg_we            cfg_index, cfg_wdata (0: frame_rows, 1: frame_cols)
//
// One pixel item is accepted per cycle while the pipeline is not stalled; the first result of an
// item passes through the line RAM read, the window, the three median stages and the output stage.
// The output stage spends one cycle per result while the results side is ready. In a filtered
// grid each item of the last row and the final item of every row from row 2 on give two results,
// the second item of the last row gives one and the final item of the grid gives three.
// Reset clears counters, window and pipeline valid bits; the line RAM is not cleared.
// A stall on the results side fills the pipeline stage by stage; nothing is dropped.
module median_filter_3x3 import mf_pkg::*; #(
    parameter int MAX_COLS     = 1024,
    parameter int MAX_ROWS     = 4096,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    mf_pix_if.sink                pixels,
    mf_res_if.source              results
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int CN_W   = COL_W + 1;
    localparam int RN_W   = ROW_W + 1;
    localparam int FL_W   = $bits(mf_flags_t);
    localparam int SIDE_W = FL_W + ROW_W + COL_W + 2 * SW;

    localparam logic [RN_W-1:0] ROWS_RST =
        RN_W'((ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ROWS_RESET);
    localparam logic [CN_W-1:0] COLS_RST =
        CN_W'((COLS_RESET > MAX_COLS) ? MAX_COLS : COLS_RESET);

    // Clamp a written size to the range 1 .. build limit.
    function automatic logic [RN_W-1:0] clamp_rows(input logic [ROWS_CFG_W-1:0] v);
        if (v == '0)
        begin
            return RN_W'(1);
        end
        else if (32'(v) > MAX_ROWS)
        begin
            return RN_W'(MAX_ROWS);
        end
        return RN_W'(v);
    endfunction

    function automatic logic [CN_W-1:0] clamp_cols(input logic [COLS_CFG_W-1:0] v);
        if (v == '0)
        begin
            return CN_W'(1);
        end
        else if (32'(v) > MAX_COLS)
        begin
            return CN_W'(MAX_COLS);
        end
        return CN_W'(v);
    endfunction

    // Configuration and position counters.
    logic [RN_W-1:0]  rows_reg;
    logic [CN_W-1:0]  cols_reg;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;

    // Position of the arriving item.
    logic             in_acc;
    logic             col_over;
    logic [RN_W-1:0]  r_pre, r_inc;
    logic [CN_W-1:0]  c_inc;
    logic [ROW_W-1:0] cur_r;
    logic [COL_W-1:0] cur_c;
    logic             last_c, last_r, pass_all;
    mf_flags_t        fl_in;

    // Stage 1: line RAM read in flight.
    logic             s1_v_reg;
    mf_flags_t        s1_fl_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [SW-1:0]    s1_pix_reg;

    // Stage 2: window holds this item's neighbourhood.
    logic             s2_v_reg;
    mf_flags_t        s2_fl_reg;
    logic [ROW_W-1:0] s2_row_reg;
    logic [COL_W-1:0] s2_col_reg;
    logic [SW-1:0]    s2_pix_reg, s2_mid_reg;
    logic [SW-1:0]    win_reg [WIN_CELLS];

    logic             free2, adv1, adv2;
    logic             med_in_ready;

    // Line RAM: upper half is the row two back, lower half the row just before.
    logic             ram_we;
    logic [2*SW-1:0]  ram_q;
    logic [SW-1:0]    ram_top, ram_mid;

    // Median pipeline outputs.
    logic              med_v;
    logic              emit_ready;
    logic [SW-1:0]     med_val;
    logic [SIDE_W-1:0] side_out;
    mf_flags_t         e_fl;
    logic [ROW_W-1:0]  e_row;
    logic [COL_W-1:0]  e_col;
    logic [SW-1:0]     e_pix, e_mid;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= ROWS_RST;
            cols_reg <= COLS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_ROWS: rows_reg <= clamp_rows(cfg_wdata[ROWS_CFG_W-1:0]);
                CFG_FRAME_COLS: cols_reg <= clamp_cols(cfg_wdata[COLS_CFG_W-1:0]);
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------ position counters
    assign in_acc = pixels.valid && pixels.ready;

    // A size written in mid-frame may leave the counters outside the grid; they
    // wrap before use, column first and then row.
    always_comb
    begin
        col_over = {1'b0, col_reg} >= cols_reg;
        r_pre    = col_over ? {1'b0, row_reg} + RN_W'(1) : {1'b0, row_reg};
        cur_r    = (r_pre >= rows_reg) ? '0 : r_pre[ROW_W-1:0];
        cur_c    = col_over ? '0 : col_reg;
        c_inc    = {1'b0, cur_c} + CN_W'(1);
        r_inc    = {1'b0, cur_r} + RN_W'(1);
        if (c_inc >= cols_reg)
        begin
            col_next = '0;
            row_next = (r_inc >= rows_reg) ? '0 : r_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = c_inc[COL_W-1:0];
            row_next = cur_r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (in_acc)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // Which results this item produces. Small grids pass through whole. Row 0
    // comes out as it arrives and row 1 gives nothing yet; from row 2 on, each item but the one in
    // column 1 completes a cell of the row above, and the last row is also sent raw straight away.
    always_comb
    begin
        last_c   = {1'b0, cur_c} == (cols_reg - CN_W'(1));
        last_r   = {1'b0, cur_r} == (rows_reg - RN_W'(1));
        pass_all = (rows_reg < RN_W'(MIN_DIM)) || (cols_reg < CN_W'(MIN_DIM));
        fl_in    = '0;
        if (pass_all)
        begin
            fl_in.pass_all     = 1'b1;
            fl_in.slot[SLOT_A] = 1'b1;
            fl_in.eof_a        = last_r && last_c;
        end
        else if (cur_r == '0)
        begin
            fl_in.slot[SLOT_A] = 1'b1;
        end
        else if (cur_r >= ROW_W'(2))
        begin
            if (cur_c == '0)
            begin
                fl_in.slot[SLOT_A] = 1'b1;
                fl_in.a_prev       = 1'b1;
            end
            else if (cur_c >= COL_W'(2))
            begin
                fl_in.slot[SLOT_A] = 1'b1;
                fl_in.a_prev       = 1'b1;
                fl_in.a_med        = 1'b1;
            end
            fl_in.slot[SLOT_B] = last_c;
            fl_in.slot[SLOT_C] = last_r;
            fl_in.eof_c        = last_c;
        end
    end

    // ------------------------------------------------------- pipeline control
    assign free2        = !s2_v_reg || med_in_ready;
    assign adv2         = s2_v_reg && med_in_ready;
    assign adv1         = s1_v_reg && free2;
    assign pixels.ready = !s1_v_reg || free2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                s1_v_reg <= 1'b1;
            end
            else if (adv1)
            begin
                s1_v_reg <= 1'b0;
            end
            if (free2)
            begin
                s2_v_reg <= s1_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_fl_reg  <= fl_in;
            s1_row_reg <= cur_r;
            s1_col_reg <= cur_c;
            s1_pix_reg <= pixels.pixel_value;
        end
        if (adv1)
        begin
            s2_fl_reg  <= s1_fl_reg;
            s2_row_reg <= s1_row_reg;
            s2_col_reg <= s1_col_reg;
            s2_pix_reg <= s1_pix_reg;
            s2_mid_reg <= ram_mid;
        end
    end

    // ------------------------------------------------------ line RAM, window
    assign ram_top = ram_q[2*SW-1:SW];
    assign ram_mid = ram_q[SW-1:0];

    // The RAM is read when the item arrives and rewritten, one row older,
    // when it moves into the window. Small grids leave RAM and window alone.
    assign ram_we = adv1 && !s1_fl_reg.pass_all;

    mf_ram #(
        .WIDTH (2 * SW),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_col_reg),
        .wdata ({ram_mid, s1_pix_reg}),
        .re    (in_acc),
        .raddr (cur_c),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_CELLS; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (ram_we)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[3*k]   <= win_reg[3*k+1];
                win_reg[3*k+1] <= win_reg[3*k+2];
            end
            win_reg[2] <= ram_top;
            win_reg[5] <= ram_mid;
            win_reg[8] <= s1_pix_reg;
        end
    end

    // ---------------------------------------------------------------- median
    mf_median #(
        .SW     (SW),
        .SIDE_W (SIDE_W)
    ) u_median (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_v_reg),
        .in_ready  (med_in_ready),
        .win       (win_reg),
        .side_in   ({s2_fl_reg, s2_row_reg, s2_col_reg, s2_pix_reg, s2_mid_reg}),
        .out_valid (med_v),
        .out_ready (emit_ready),
        .med       (med_val),
        .side_out  (side_out)
    );

    assign {e_fl, e_row, e_col, e_pix, e_mid} = side_out;

    // ---------------------------------------------------------------- output
    mf_emit #(
        .ROW_W (ROW_W),
        .COL_W (COL_W),
        .SW    (SW)
    ) u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (med_v),
        .in_ready (emit_ready),
        .flags    (e_fl),
        .row      (e_row),
        .col      (e_col),
        .pix      (e_pix),
        .mid      (e_mid),
        .med      (med_val),
        .res      (results)
    );

`ifndef SYNTHESIS
    // After an item the column counter lies inside the grid.
    a_col_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && !cfg_we |=> ({1'b0, col_reg} < cols_reg))
        else $error("column counter left the grid");

    // After an item the row counter lies inside the grid.
    a_row_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && !cfg_we |=> ({1'b0, row_reg} < rows_reg))
        else $error("row counter left the grid");

    // An item held in the window stage keeps its position while it waits.
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_v_reg && !adv2 |=> s2_v_reg && $stable(s2_row_reg) && $stable(s2_col_reg))
        else $error("window stage item changed while stalled");
`endif

endmodule
